// ===== design/one_euro_filter_2d_defines.svh =====
// Assertion macros shared by the checkers of the filter block.
// Each one samples on clk and is disabled while arst_n is low.
`ifndef ONE_EURO_FILTER_2D_DEFINES_SVH
`define ONE_EURO_FILTER_2D_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define OEF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("one_euro_filter_2d check failed");

// Consequent holds in the cycle after the antecedent.
`define OEF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("one_euro_filter_2d check failed");

`endif

// ===== design/oef_pkg.sv =====
package oef_pkg;

	// Input beat
	typedef struct packed {
		logic        cmd;
		logic [31:0] time_ms;
		logic [31:0] x_in;
		logic [31:0] y_in;
	} in_t;

	// Result beat
	typedef struct packed {
		logic [31:0] x_out;
		logic [31:0] y_out;
	} out_t;

	// Divider request and response
	typedef struct packed {
		logic        start;
		logic [39:0] rem;
		logic [63:0] quo;
		logic [39:0] divisor;
		logic [5:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	// Commands
	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// Register indexes
	localparam logic [1:0] CFG_MIN_CUTOFF   = 2'd0;
	localparam logic [1:0] CFG_SPEED_GAIN   = 2'd1;
	localparam logic [1:0] CFG_DERIV_CUTOFF = 2'd2;

	// 2*pi in Q3.29
	localparam logic [31:0] TWOPI_Q29 = 32'd3373259426;
	localparam int ALPHA_BITS = 28;

	// Divider step counts
	localparam logic [5:0] SPD_DIV_STEPS   = 6'd43;
	localparam logic [5:0] ALPHA_DIV_STEPS = 6'd28;

endpackage

// ===== design/oef_div.sv =====
module oef_div (
	input  logic              clk,
	input  logic              arst_n,
	input  oef_pkg::div_req_t req,
	output oef_pkg::div_rsp_t rsp
);
	import oef_pkg::*;

	logic [39:0] rem_q;
	logic [63:0] quo_q;
	logic [39:0] divisor_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [39:0] rs;
	logic        ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rs = {rem_q[38:0], quo_q[63]};
		ge = (rs >= divisor_q);
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.rem;
			quo_q     <= req.quo;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (rs - divisor_q) : rs;
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== design/one_euro_filter_2d.sv =====
// channel | dir | handshake              | payload
// in      | in  | in_valid / in_ready    | in_data   (cmd, time_ms, x_in, y_in)
// out     | out | out_valid / out_ready  | out_data  (x_out, y_out)
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A sample holds the sequencer until its result enters the output register,
// plus any wait for that register; its length is set by the shared bit-serial
// divider (43 steps per speed, 28 per smoothing factor) and the one-bit-per-cycle
// normalize of fc*dt. A clear is handled while idle; a first sample only seeds
// the filter state. in_ready is high only while the sequencer is idle; one
// finished result waits in the output register while the next sample is accepted.
// Reset is asynchronous, active low; cfg_ready is always high.
module one_euro_filter_2d #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  oef_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output oef_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import oef_pkg::*;

	localparam logic [39:0] DERIV_D = 40'd1000 << FRAC_BITS;

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_SPD_MUL = 14'b00000000000010,
		S_SPD_DV0 = 14'b00000000000100,
		S_SPD_DIV = 14'b00000000001000,
		S_CUT_MUL = 14'b00000000010000,
		S_CUT_ADD = 14'b00000000100000,
		S_AL_MUL  = 14'b00000001000000,
		S_AL_LOAD = 14'b00000010000000,
		S_AL_NORM = 14'b00000100000000,
		S_AL_DV0  = 14'b00001000000000,
		S_AL_DIV  = 14'b00010000000000,
		S_LP_MUL  = 14'b00100000000000,
		S_LP_ADD  = 14'b01000000000000,
		S_FIN     = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Registers
	logic [31:0] min_cutoff_q, speed_gain_q, deriv_cutoff_q;
	logic        started_q, speed_started_q;
	logic [31:0] last_time_q;
	logic [31:0] last_raw_q [2];
	logic [31:0] smooth_pos_q [2];
	logic [31:0] smooth_speed_q [2];
	logic [31:0] raw_q [2];
	logic [31:0] dt_q;
	logic        axis_q;
	logic        sel_d_q;
	logic [31:0] spd_q;
	logic [31:0] fc_q;
	logic [63:0] k_q;
	logic [39:0] d_q;
	logic [28:0] alpha_q, alpha_d_q;
	logic [65:0] prod_q;
	logic        out_valid_q;
	out_t        out_q;

	// Datapath
	logic [32:0] mul_a, mul_b;
	logic [31:0] raw_v, lr_v, ss_v, sp_v;
	logic [32:0] spd_diff, spd_mag;
	logic [31:0] ss_mag;
	logic [42:0] spd_qm;
	logic [31:0] spd_sat;
	logic [31:0] lp_prev, lp_x;
	logic [28:0] lp_alpha;
	logic [32:0] lp_diff, lp_mag;
	logic [61:0] lp_sum;
	logic [33:0] lp_res;
	logic [65:0] cut_sum;
	logic [31:0] cut_sat;
	logic [34:0] num;
	logic [39:0] al_div;
	logic [31:0] d_raw, dt_new;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	oef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Per-axis operands
	always_comb begin
		raw_v    = raw_q[axis_q];
		lr_v     = last_raw_q[axis_q];
		ss_v     = smooth_speed_q[axis_q];
		sp_v     = smooth_pos_q[axis_q];
		spd_diff = {raw_v[31], raw_v} - {lr_v[31], lr_v};
		spd_mag  = spd_diff[32] ? (33'd0 - spd_diff) : spd_diff;
		ss_mag   = ss_v[31] ? (32'd0 - ss_v) : ss_v;
		spd_qm   = div_rsp.quotient[42:0];
		if (!spd_diff[32]) begin
			spd_sat = (spd_qm > 43'h7FFFFFFF) ? 32'h7FFFFFFF : spd_qm[31:0];
		end else begin
			spd_sat = (spd_qm > 43'h80000000) ? 32'h80000000 : (32'd0 - spd_qm[31:0]);
		end
		lp_prev  = sel_d_q ? ss_v : sp_v;
		lp_x     = sel_d_q ? spd_q : raw_v;
		lp_alpha = sel_d_q ? alpha_d_q : alpha_q;
		lp_diff  = {lp_x[31], lp_x} - {lp_prev[31], lp_prev};
		lp_mag   = lp_diff[32] ? (33'd0 - lp_diff) : lp_diff;
		lp_sum   = prod_q[61:0] + (62'd1 << (ALPHA_BITS - 1));
		lp_res   = lp_diff[32] ? ({{2{lp_prev[31]}}, lp_prev} - lp_sum[61:28])
		                       : ({{2{lp_prev[31]}}, lp_prev} + lp_sum[61:28]);
		cut_sum  = {34'd0, min_cutoff_q} + (prod_q >> FRAC_BITS);
		cut_sat  = (|cut_sum[65:32]) ? 32'hFFFFFFFF : cut_sum[31:0];
		num      = prod_q[63:29];
		al_div   = {5'd0, num} + d_q;
		d_raw    = in_data.time_ms - last_time_q;
		dt_new   = (d_raw == 32'd0 || d_raw[31]) ? 32'd1 : d_raw;
	end

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SPD_MUL: begin
				mul_a = spd_mag;
				mul_b = 33'd1000;
			end
			S_CUT_MUL: begin
				mul_a = {1'b0, speed_gain_q};
				mul_b = {1'b0, ss_mag};
			end
			S_AL_MUL: begin
				mul_a = {1'b0, fc_q};
				mul_b = {1'b0, dt_q};
			end
			S_AL_NORM: begin
				mul_a = {1'b0, k_q[31:0]};
				mul_b = {1'b0, TWOPI_Q29};
			end
			S_LP_MUL: begin
				mul_a = lp_mag;
				mul_b = {4'd0, lp_alpha};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Divider requests
	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_SPD_DV0: begin
				div_req.start   = 1'b1;
				div_req.quo     = {prod_q[42:0], 21'd0};
				div_req.divisor = {8'd0, dt_q};
				div_req.steps   = SPD_DIV_STEPS;
			end
			S_AL_DV0: begin
				div_req.start   = (d_q != 40'd0);
				div_req.rem     = {5'd0, num};
				div_req.divisor = al_div;
				div_req.steps   = ALPHA_DIV_STEPS;
			end
			default: div_req = '0;
		endcase
	end

	// Product register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cutoff_q   <= 32'd1 << FRAC_BITS;
			speed_gain_q   <= '0;
			deriv_cutoff_q <= 32'd1 << FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MIN_CUTOFF)   min_cutoff_q   <= cfg_data;
			if (cfg_index == CFG_SPEED_GAIN)   speed_gain_q   <= cfg_data;
			if (cfg_index == CFG_DERIV_CUTOFF) deriv_cutoff_q <= cfg_data;
		end
	end

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			started_q       <= 1'b0;
			speed_started_q <= 1'b0;
			last_time_q     <= '0;
			last_raw_q      <= '{default: '0};
			smooth_pos_q    <= '{default: '0};
			smooth_speed_q  <= '{default: '0};
			raw_q           <= '{default: '0};
			dt_q            <= '0;
			axis_q          <= 1'b0;
			sel_d_q         <= 1'b0;
			spd_q           <= '0;
			fc_q            <= '0;
			k_q             <= '0;
			d_q             <= '0;
			alpha_q         <= '0;
			alpha_d_q       <= '0;
			out_valid_q     <= 1'b0;
			out_q           <= '0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != S_FIN) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.cmd == CMD_CLEAR) begin
							started_q       <= 1'b0;
							speed_started_q <= 1'b0;
							last_time_q     <= '0;
							last_raw_q      <= '{default: '0};
							smooth_pos_q    <= '{default: '0};
							smooth_speed_q  <= '{default: '0};
						end else if (!started_q) begin
							started_q       <= 1'b1;
							last_time_q     <= in_data.time_ms;
							last_raw_q[0]   <= in_data.x_in;
							last_raw_q[1]   <= in_data.y_in;
							smooth_pos_q[0] <= in_data.x_in;
							smooth_pos_q[1] <= in_data.y_in;
							state_q         <= S_FIN;
						end else begin
							last_time_q <= in_data.time_ms;
							dt_q        <= dt_new;
							raw_q[0]    <= in_data.x_in;
							raw_q[1]    <= in_data.y_in;
							axis_q      <= 1'b0;
							state_q     <= S_SPD_MUL;
						end
					end
				end
				S_SPD_MUL: state_q <= S_SPD_DV0;
				S_SPD_DV0: state_q <= S_SPD_DIV;
				S_SPD_DIV: begin
					if (div_rsp.done) begin
						spd_q <= spd_sat;
						if (!speed_started_q) begin
							smooth_speed_q[axis_q] <= spd_sat;
							state_q <= S_CUT_MUL;
						end else if (!axis_q) begin
							// deriv factor is shared by both axes
							fc_q    <= deriv_cutoff_q;
							sel_d_q <= 1'b1;
							state_q <= S_AL_MUL;
						end else begin
							sel_d_q <= 1'b1;
							state_q <= S_LP_MUL;
						end
					end
				end
				S_CUT_MUL: state_q <= S_CUT_ADD;
				S_CUT_ADD: begin
					fc_q    <= cut_sat;
					sel_d_q <= 1'b0;
					state_q <= S_AL_MUL;
				end
				S_AL_MUL: state_q <= S_AL_LOAD;
				S_AL_LOAD: begin
					k_q     <= prod_q[63:0];
					d_q     <= DERIV_D;
					state_q <= S_AL_NORM;
				end
				S_AL_NORM: begin
					// shift until fc*dt fits in 32 bits
					if (|k_q[63:32]) begin
						k_q <= k_q >> 1;
						d_q <= d_q >> 1;
					end else begin
						state_q <= S_AL_DV0;
					end
				end
				S_AL_DV0: begin
					if (d_q == 40'd0) begin
						if (sel_d_q) alpha_d_q <= 29'd1 << ALPHA_BITS;
						else         alpha_q   <= 29'd1 << ALPHA_BITS;
						state_q <= S_LP_MUL;
					end else begin
						state_q <= S_AL_DIV;
					end
				end
				S_AL_DIV: begin
					if (div_rsp.done) begin
						if (sel_d_q) alpha_d_q <= div_rsp.quotient[28:0];
						else         alpha_q   <= div_rsp.quotient[28:0];
						state_q <= S_LP_MUL;
					end
				end
				S_LP_MUL: state_q <= S_LP_ADD;
				S_LP_ADD: begin
					if (sel_d_q) begin
						smooth_speed_q[axis_q] <= lp_res[31:0];
						state_q <= S_CUT_MUL;
					end else begin
						smooth_pos_q[axis_q] <= lp_res[31:0];
						last_raw_q[axis_q]   <= raw_v;
						if (!axis_q) begin
							axis_q  <= 1'b1;
							state_q <= S_SPD_MUL;
						end else begin
							speed_started_q <= 1'b1;
							state_q         <= S_FIN;
						end
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.x_out <= smooth_pos_q[0];
						out_q.y_out <= smooth_pos_q[1];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/oef_chk.sv =====
`include "one_euro_filter_2d_defines.svh"

module oef_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input oef_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input oef_pkg::out_t out_data
);
	import oef_pkg::*;

	// A stalled result keeps its beat
	`OEF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// A sample occupies the sequencer after it is taken
	`OEF_ASSERT_NEXT(a_busy_after_sample, in_valid && in_ready && in_data.cmd == CMD_FILTER, !in_ready)

	// A clear leaves the input ready after it is taken
	`OEF_ASSERT_NEXT(a_clear_ready, in_valid && in_ready && in_data.cmd == CMD_CLEAR, in_ready)

endmodule

bind one_euro_filter_2d oef_chk u_oef_chk (.*);
